### rtl/rv32id_pkg.sv
package rv32id_pkg;

   // Major opcodes, bits 6:0 of the instruction word.
   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_FENCE  = 7'b0001111;
   localparam logic [6:0] OP_SYSTEM = 7'b1110011;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;
   localparam logic [6:0] F7_MULD = 7'b0000001;

   // Dense mnemonic codes.
   localparam logic [5:0] MN_UNKNOWN = 6'd0;
   localparam logic [5:0] MN_LUI     = 6'd1;
   localparam logic [5:0] MN_AUIPC   = 6'd2;
   localparam logic [5:0] MN_JAL     = 6'd3;
   localparam logic [5:0] MN_JALR    = 6'd4;
   localparam logic [5:0] MN_BEQ     = 6'd5;
   localparam logic [5:0] MN_BNE     = 6'd6;
   localparam logic [5:0] MN_BLT     = 6'd7;
   localparam logic [5:0] MN_BGE     = 6'd8;
   localparam logic [5:0] MN_BLTU    = 6'd9;
   localparam logic [5:0] MN_BGEU    = 6'd10;
   localparam logic [5:0] MN_LB      = 6'd11;
   localparam logic [5:0] MN_LH      = 6'd12;
   localparam logic [5:0] MN_LW      = 6'd13;
   localparam logic [5:0] MN_LBU     = 6'd14;
   localparam logic [5:0] MN_LHU     = 6'd15;
   localparam logic [5:0] MN_SB      = 6'd16;
   localparam logic [5:0] MN_SH      = 6'd17;
   localparam logic [5:0] MN_SW      = 6'd18;
   localparam logic [5:0] MN_ADDI    = 6'd19;
   localparam logic [5:0] MN_SLTI    = 6'd20;
   localparam logic [5:0] MN_SLTIU   = 6'd21;
   localparam logic [5:0] MN_XORI    = 6'd22;
   localparam logic [5:0] MN_ORI     = 6'd23;
   localparam logic [5:0] MN_ANDI    = 6'd24;
   localparam logic [5:0] MN_SLLI    = 6'd25;
   localparam logic [5:0] MN_SRLI    = 6'd26;
   localparam logic [5:0] MN_SRAI    = 6'd27;
   localparam logic [5:0] MN_ADD     = 6'd28;
   localparam logic [5:0] MN_SUB     = 6'd29;
   localparam logic [5:0] MN_SLL     = 6'd30;
   localparam logic [5:0] MN_SLT     = 6'd31;
   localparam logic [5:0] MN_SLTU    = 6'd32;
   localparam logic [5:0] MN_XOR     = 6'd33;
   localparam logic [5:0] MN_SRL     = 6'd34;
   localparam logic [5:0] MN_SRA     = 6'd35;
   localparam logic [5:0] MN_OR      = 6'd36;
   localparam logic [5:0] MN_AND     = 6'd37;
   localparam logic [5:0] MN_MUL     = 6'd38;
   localparam logic [5:0] MN_FENCE   = 6'd46;
   localparam logic [5:0] MN_ECALL   = 6'd47;
   localparam logic [5:0] MN_EBREAK  = 6'd48;

   // Operand format codes.
   localparam logic [3:0] FMT_NONE  = 4'd0;
   localparam logic [3:0] FMT_U     = 4'd1;
   localparam logic [3:0] FMT_J     = 4'd2;
   localparam logic [3:0] FMT_B     = 4'd3;
   localparam logic [3:0] FMT_LOAD  = 4'd4;
   localparam logic [3:0] FMT_STORE = 4'd5;
   localparam logic [3:0] FMT_IALU  = 4'd6;
   localparam logic [3:0] FMT_SHIFT = 4'd7;
   localparam logic [3:0] FMT_R     = 4'd8;
   localparam logic [3:0] FMT_FENCE = 4'd9;

   typedef struct packed {
      logic [31:0] word;
      logic [31:0] pc;
   } req_type;

   typedef struct packed {
      logic [5:0]         mnemonic;
      logic [3:0]         format;
      logic [4:0]         rd;
      logic [4:0]         rs1;
      logic [4:0]         rs2;
      logic signed [31:0] immediate;
      logic [4:0]         shift_amount;
      logic [31:0]        target;
      logic               needs_label;
   } rsp_type;

endpackage

### rtl/rv32im_instruction_decoder_unit.sv
// RV32IM instruction decoder. An item (instruction word and its address) is
// taken whenever start is high; busy is always low, so one item can enter in
// every cycle. The result appears on rsp_item with rsp_strobe high for exactly
// one cycle. The item passes through the input register and then the result
// register, with the whole decode and the pc-plus-immediate add in the single
// combinational pass between them. Results come out in the order the items
// went in. The receiver cannot stall the block and must take each result in the
// cycle it is shown. Unknown encodings give mnemonic and format zero, with
// immediate, shift amount, target and label flag zero; rd, rs1 and rs2 always
// carry the raw bits.
module rv32im_instruction_decoder_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rv32id_pkg::req_type req_item,
   output logic                rsp_strobe,
   output rv32id_pkg::rsp_type rsp_item
);

   logic                req_valid_ff;
   rv32id_pkg::req_type req_ff;
   logic                rsp_strobe_ff;
   rv32id_pkg::rsp_type rsp_ff;
   rv32id_pkg::rsp_type rsp_in;

   logic [31:0] w;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;

   assign busy = 1'b0;

   assign w     = req_ff.word;
   assign opc   = w[6:0];
   assign f3    = w[14:12];
   assign f7    = w[31:25];
   assign imm_i = {{20{w[31]}}, w[31:20]};
   assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
   assign imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
   assign imm_u = {12'd0, w[31:12]};

   always_comb begin
      logic [5:0]  mn;
      logic [3:0]  fmt;
      logic [31:0] imm;
      logic [4:0]  sh;
      logic        label;

      mn    = rv32id_pkg::MN_UNKNOWN;
      fmt   = rv32id_pkg::FMT_NONE;
      imm   = 32'd0;
      sh    = 5'd0;
      label = 1'b0;

      unique case (opc)
         rv32id_pkg::OP_LUI: begin
            mn  = rv32id_pkg::MN_LUI;
            fmt = rv32id_pkg::FMT_U;
            imm = imm_u;
         end
         rv32id_pkg::OP_AUIPC: begin
            mn  = rv32id_pkg::MN_AUIPC;
            fmt = rv32id_pkg::FMT_U;
            imm = imm_u;
         end
         rv32id_pkg::OP_JAL: begin
            mn    = rv32id_pkg::MN_JAL;
            fmt   = rv32id_pkg::FMT_J;
            imm   = imm_j;
            label = 1'b1;
         end
         rv32id_pkg::OP_JALR: begin
            if (f3 == 3'd0) begin
               mn  = rv32id_pkg::MN_JALR;
               fmt = rv32id_pkg::FMT_LOAD;
               imm = imm_i;
            end
         end
         rv32id_pkg::OP_BRANCH: begin
            unique case (f3)
               3'd0:    mn = rv32id_pkg::MN_BEQ;
               3'd1:    mn = rv32id_pkg::MN_BNE;
               3'd4:    mn = rv32id_pkg::MN_BLT;
               3'd5:    mn = rv32id_pkg::MN_BGE;
               3'd6:    mn = rv32id_pkg::MN_BLTU;
               3'd7:    mn = rv32id_pkg::MN_BGEU;
               default: mn = rv32id_pkg::MN_UNKNOWN;
            endcase
            if (mn != rv32id_pkg::MN_UNKNOWN) begin
               fmt   = rv32id_pkg::FMT_B;
               imm   = imm_b;
               label = 1'b1;
            end
         end
         rv32id_pkg::OP_LOAD: begin
            unique case (f3)
               3'd0:    mn = rv32id_pkg::MN_LB;
               3'd1:    mn = rv32id_pkg::MN_LH;
               3'd2:    mn = rv32id_pkg::MN_LW;
               3'd4:    mn = rv32id_pkg::MN_LBU;
               3'd5:    mn = rv32id_pkg::MN_LHU;
               default: mn = rv32id_pkg::MN_UNKNOWN;
            endcase
            if (mn != rv32id_pkg::MN_UNKNOWN) begin
               fmt = rv32id_pkg::FMT_LOAD;
               imm = imm_i;
            end
         end
         rv32id_pkg::OP_STORE: begin
            unique case (f3)
               3'd0:    mn = rv32id_pkg::MN_SB;
               3'd1:    mn = rv32id_pkg::MN_SH;
               3'd2:    mn = rv32id_pkg::MN_SW;
               default: mn = rv32id_pkg::MN_UNKNOWN;
            endcase
            if (mn != rv32id_pkg::MN_UNKNOWN) begin
               fmt = rv32id_pkg::FMT_STORE;
               imm = imm_s;
            end
         end
         rv32id_pkg::OP_IMM: begin
            unique case (f3)
               3'd0: mn = rv32id_pkg::MN_ADDI;
               3'd2: mn = rv32id_pkg::MN_SLTI;
               3'd3: mn = rv32id_pkg::MN_SLTIU;
               3'd4: mn = rv32id_pkg::MN_XORI;
               3'd6: mn = rv32id_pkg::MN_ORI;
               3'd7: mn = rv32id_pkg::MN_ANDI;
               3'd1: begin
                  if (f7 == rv32id_pkg::F7_BASE) begin
                     mn = rv32id_pkg::MN_SLLI;
                  end
               end
               3'd5: begin
                  if (f7 == rv32id_pkg::F7_BASE) begin
                     mn = rv32id_pkg::MN_SRLI;
                  end else if (f7 == rv32id_pkg::F7_ALT) begin
                     mn = rv32id_pkg::MN_SRAI;
                  end
               end
            endcase
            // Shifts carry their amount instead of an immediate.
            if (f3 == 3'd1 || f3 == 3'd5) begin
               if (mn != rv32id_pkg::MN_UNKNOWN) begin
                  fmt = rv32id_pkg::FMT_SHIFT;
                  sh  = w[24:20];
               end
            end else begin
               fmt = rv32id_pkg::FMT_IALU;
               imm = imm_i;
            end
         end
         rv32id_pkg::OP_REG: begin
            if (f7 == rv32id_pkg::F7_BASE) begin
               unique case (f3)
                  3'd0: mn = rv32id_pkg::MN_ADD;
                  3'd1: mn = rv32id_pkg::MN_SLL;
                  3'd2: mn = rv32id_pkg::MN_SLT;
                  3'd3: mn = rv32id_pkg::MN_SLTU;
                  3'd4: mn = rv32id_pkg::MN_XOR;
                  3'd5: mn = rv32id_pkg::MN_SRL;
                  3'd6: mn = rv32id_pkg::MN_OR;
                  3'd7: mn = rv32id_pkg::MN_AND;
               endcase
            end else if (f7 == rv32id_pkg::F7_ALT) begin
               if (f3 == 3'd0) begin
                  mn = rv32id_pkg::MN_SUB;
               end else if (f3 == 3'd5) begin
                  mn = rv32id_pkg::MN_SRA;
               end
            end else if (f7 == rv32id_pkg::F7_MULD) begin
               // The M extension codes follow funct3 in order from mul.
               mn = rv32id_pkg::MN_MUL + {3'd0, f3};
            end
            if (mn != rv32id_pkg::MN_UNKNOWN) begin
               fmt = rv32id_pkg::FMT_R;
            end
         end
         rv32id_pkg::OP_FENCE: begin
            if (f3 == 3'd0) begin
               mn  = rv32id_pkg::MN_FENCE;
               fmt = rv32id_pkg::FMT_FENCE;
            end
         end
         rv32id_pkg::OP_SYSTEM: begin
            // ecall and ebreak keep format none; bit 20 tells them apart.
            if (f3 == 3'd0 && w[31:21] == 11'd0) begin
               mn = w[20] ? rv32id_pkg::MN_EBREAK : rv32id_pkg::MN_ECALL;
            end
         end
         default: begin
            mn = rv32id_pkg::MN_UNKNOWN;
         end
      endcase

      rsp_in.mnemonic     = mn;
      rsp_in.format       = fmt;
      rsp_in.rd           = w[11:7];
      rsp_in.rs1          = w[19:15];
      rsp_in.rs2          = w[24:20];
      rsp_in.immediate    = imm;
      rsp_in.shift_amount = sh;
      rsp_in.target       = label ? (req_ff.pc + imm) : 32'd0;
      rsp_in.needs_label  = label;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
      end
      req_ff <= req_item;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_strobe)
      else $error("accepted item produced no result two cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("result strobe without an accepted item");

   a_label_fmt: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.needs_label |->
         (rsp_item.format == rv32id_pkg::FMT_J || rsp_item.format == rv32id_pkg::FMT_B))
      else $error("label flag on a non-control-flow format");

   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.needs_label |-> rsp_item.target == 32'd0)
      else $error("target set without label flag");

   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.mnemonic == rv32id_pkg::MN_UNKNOWN |->
         rsp_item.format == rv32id_pkg::FMT_NONE && rsp_item.immediate == 32'sd0 &&
         rsp_item.shift_amount == 5'd0)
      else $error("unknown word with nonzero decode fields");
`endif

endmodule

### tb/sv/rv32im_instruction_decoder_unit_tb.sv
`timescale 1ns / 1ps

module rv32im_instruction_decoder_unit_tb;
   import rv32id_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_PRINTED    = 40;

   localparam logic [5:0] MN_REMU = MN_MUL + 6'd7;
   localparam logic [2:0] F3_SHL  = 3'd1;
   localparam logic [2:0] F3_SHR  = 3'd5;

   // Mnemonic per funct3, entry 0 in the low six bits.
   localparam logic [47:0] BRANCH_MAP = {MN_BGEU, MN_BLTU, MN_BGE, MN_BLT,
                                         MN_UNKNOWN, MN_UNKNOWN, MN_BNE, MN_BEQ};
   localparam logic [47:0] LOAD_MAP = {MN_UNKNOWN, MN_UNKNOWN, MN_LHU, MN_LBU,
                                       MN_UNKNOWN, MN_LW, MN_LH, MN_LB};
   localparam logic [47:0] STORE_MAP = {MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN,
                                        MN_UNKNOWN, MN_SW, MN_SH, MN_SB};
   localparam logic [47:0] IALU_MAP = {MN_ANDI, MN_ORI, MN_UNKNOWN, MN_XORI,
                                       MN_SLTIU, MN_SLTI, MN_UNKNOWN, MN_ADDI};
   localparam logic [47:0] REG_BASE_MAP = {MN_AND, MN_OR, MN_SRL, MN_XOR,
                                           MN_SLTU, MN_SLT, MN_SLL, MN_ADD};
   localparam logic [47:0] REG_ALT_MAP = {MN_UNKNOWN, MN_UNKNOWN, MN_SRA, MN_UNKNOWN,
                                          MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN, MN_SUB};
   localparam logic [76:0] OPCODE_LIST = {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
                                          OP_LOAD, OP_STORE, OP_IMM, OP_REG, OP_FENCE,
                                          OP_SYSTEM};

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   rsp_type     pending_decodes[$];
   int          idle_pct;
   int          error_count;
   int          items_taken;
   int          results_checked;
   int          stall_cycles;
   logic [63:0] mnemonics_seen;

   rv32im_instruction_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type decode_instruction(input logic [31:0] w, input logic [31:0] pc);
      rsp_type     r;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm_i;
      r = '0;
      f3 = w[14:12];
      f7 = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      r.rd = w[11:7];
      r.rs1 = w[19:15];
      r.rs2 = w[24:20];
      case (w[6:0])
         OP_LUI, OP_AUIPC: begin
            r.mnemonic = (w[6:0] == OP_LUI) ? MN_LUI : MN_AUIPC;
            r.format = FMT_U;
            r.immediate = {12'b0, w[31:12]};
         end
         OP_JAL: begin
            r.mnemonic = MN_JAL;
            r.format = FMT_J;
            r.needs_label = 1'b1;
            r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         OP_JALR: begin
            if (f3 == '0) begin
               r.mnemonic = MN_JALR;
               r.format = FMT_LOAD;
               r.immediate = imm_i;
            end
         end
         OP_BRANCH: begin
            r.mnemonic = BRANCH_MAP[f3 * 6 +: 6];
            if (r.mnemonic != MN_UNKNOWN) begin
               r.format = FMT_B;
               r.needs_label = 1'b1;
               r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
         end
         OP_LOAD: begin
            r.mnemonic = LOAD_MAP[f3 * 6 +: 6];
            if (r.mnemonic != MN_UNKNOWN) begin
               r.format = FMT_LOAD;
               r.immediate = imm_i;
            end
         end
         OP_STORE: begin
            r.mnemonic = STORE_MAP[f3 * 6 +: 6];
            if (r.mnemonic != MN_UNKNOWN) begin
               r.format = FMT_STORE;
               r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
            end
         end
         OP_IMM: begin
            if (f3 == F3_SHL) begin
               if (f7 == F7_BASE) r.mnemonic = MN_SLLI;
            end else if (f3 == F3_SHR) begin
               if (f7 == F7_BASE) r.mnemonic = MN_SRLI;
               else if (f7 == F7_ALT) r.mnemonic = MN_SRAI;
            end else begin
               r.mnemonic = IALU_MAP[f3 * 6 +: 6];
               if (r.mnemonic != MN_UNKNOWN) begin
                  r.format = FMT_IALU;
                  r.immediate = imm_i;
               end
            end
            if (r.mnemonic >= MN_SLLI && r.mnemonic <= MN_SRAI) begin
               r.format = FMT_SHIFT;
               r.shift_amount = w[24:20];
            end
         end
         OP_REG: begin
            if (f7 == F7_BASE) r.mnemonic = REG_BASE_MAP[f3 * 6 +: 6];
            else if (f7 == F7_ALT) r.mnemonic = REG_ALT_MAP[f3 * 6 +: 6];
            else if (f7 == F7_MULD) r.mnemonic = MN_MUL + 6'(f3);
            if (r.mnemonic != MN_UNKNOWN) r.format = FMT_R;
         end
         OP_FENCE: begin
            if (f3 == '0) begin
               r.mnemonic = MN_FENCE;
               r.format = FMT_FENCE;
            end
         end
         OP_SYSTEM: begin
            // Only bit 20 may be set in the upper field; rd and rs1 are ignored.
            if (f3 == '0 && w[31:21] == '0) r.mnemonic = w[20] ? MN_EBREAK : MN_ECALL;
         end
         default: ;
      endcase
      if (r.needs_label) r.target = pc + r.immediate;
      return r;
   endfunction

   function automatic logic [2:0] map_slot(input logic [47:0] m, input logic [5:0] mn);
      logic [2:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         if (m[i * 6 +: 6] == mn) s = 3'(i);
      end
      return s;
   endfunction

   // Random word that decodes to the given mnemonic; unknown leaves it fully random.
   function automatic logic [31:0] encode_mnemonic(input logic [5:0] mn);
      logic [31:0] w;
      w = $urandom();
      if (mn == MN_LUI) begin
         w[6:0] = OP_LUI;
      end else if (mn == MN_AUIPC) begin
         w[6:0] = OP_AUIPC;
      end else if (mn == MN_JAL) begin
         w[6:0] = OP_JAL;
      end else if (mn == MN_JALR) begin
         w[6:0] = OP_JALR;
         w[14:12] = '0;
      end else if (mn >= MN_BEQ && mn <= MN_BGEU) begin
         w[6:0] = OP_BRANCH;
         w[14:12] = map_slot(BRANCH_MAP, mn);
      end else if (mn >= MN_LB && mn <= MN_LHU) begin
         w[6:0] = OP_LOAD;
         w[14:12] = map_slot(LOAD_MAP, mn);
      end else if (mn >= MN_SB && mn <= MN_SW) begin
         w[6:0] = OP_STORE;
         w[14:12] = map_slot(STORE_MAP, mn);
      end else if (mn >= MN_ADDI && mn <= MN_ANDI) begin
         w[6:0] = OP_IMM;
         w[14:12] = map_slot(IALU_MAP, mn);
      end else if (mn >= MN_SLLI && mn <= MN_SRAI) begin
         w[6:0] = OP_IMM;
         w[14:12] = (mn == MN_SLLI) ? F3_SHL : F3_SHR;
         w[31:25] = (mn == MN_SRAI) ? F7_ALT : F7_BASE;
      end else if (mn == MN_SUB || mn == MN_SRA) begin
         w[6:0] = OP_REG;
         w[14:12] = map_slot(REG_ALT_MAP, mn);
         w[31:25] = F7_ALT;
      end else if (mn >= MN_ADD && mn <= MN_AND) begin
         w[6:0] = OP_REG;
         w[14:12] = map_slot(REG_BASE_MAP, mn);
         w[31:25] = F7_BASE;
      end else if (mn >= MN_MUL && mn <= MN_REMU) begin
         w[6:0] = OP_REG;
         w[14:12] = 3'(mn - MN_MUL);
         w[31:25] = F7_MULD;
      end else if (mn == MN_FENCE) begin
         w[6:0] = OP_FENCE;
         w[14:12] = '0;
      end else if (mn == MN_ECALL || mn == MN_EBREAK) begin
         w[6:0] = OP_SYSTEM;
         w[14:12] = '0;
         w[31:21] = '0;
         w[20] = (mn == MN_EBREAK);
      end
      return w;
   endfunction

   function automatic logic [31:0] random_pc();
      logic [31:0] p;
      case ($urandom_range(7))
         0: p = '0;
         1: p = '1;
         2: p = 32'hFFFF_F000 + $urandom_range(4095);
         3: p = $urandom_range(4095);
         default: p = $urandom();
      endcase
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want, input logic [31:0] word);
      if (got !== want)
         report_mismatch($sformatf("word %h: %s is %h, expected %h", word, name, got, want));
   endtask

   task automatic compare_result(input rsp_type got, input rsp_type want, input logic [31:0] word);
      compare_field("mnemonic", 32'(got.mnemonic), 32'(want.mnemonic), word);
      compare_field("format", 32'(got.format), 32'(want.format), word);
      compare_field("rd", 32'(got.rd), 32'(want.rd), word);
      compare_field("rs1", 32'(got.rs1), 32'(want.rs1), word);
      compare_field("rs2", 32'(got.rs2), 32'(want.rs2), word);
      compare_field("immediate", got.immediate, want.immediate, word);
      compare_field("shift_amount", 32'(got.shift_amount), 32'(want.shift_amount), word);
      compare_field("target", got.target, want.target, word);
      compare_field("needs_label", 32'(got.needs_label), 32'(want.needs_label), word);
   endtask

   // The raw word is kept alongside each prediction so mismatches can name it.
   logic [31:0] pending_words[$];

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (pending_decodes.size() == 0) begin
               report_mismatch($sformatf("result mnemonic %0d with no item pending",
                                         rsp_item.mnemonic));
            end else begin
               compare_result(rsp_item, pending_decodes.pop_front(), pending_words.pop_front());
               results_checked++;
               if (rsp_item.mnemonic <= MN_EBREAK) mnemonics_seen[rsp_item.mnemonic] = 1'b1;
            end
         end
         if (start && busy === 1'b0) begin
            pending_decodes.push_back(decode_instruction(req_item.word, req_item.pc));
            pending_words.push_back(req_item.word);
            items_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input logic [31:0] w, input logic [31:0] p);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= req_type'{w, p};
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      @(posedge clock);
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   task automatic test_special_cases();
      send_item(32'h0000_0000, 32'h0000_0000);   // opcode zero is unknown
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all ones is unknown
      send_item(32'hFFFF_F0B7, 32'h0000_0000);   // lui, U field all ones, not shifted
      send_item(32'h0000_0017, 32'hFFFF_FFFF);   // auipc, zero field
      send_item(32'hFFFF_F06F, 32'h0000_0000);   // jal, offset -2, target wraps
      send_item(32'h7FFF_FFEF, 32'hFFFF_F000);   // jal, largest offset, target wraps
      send_item(32'hFE00_0FE3, 32'h0000_0000);   // beq, offset -2
      send_item(32'h7E00_7FE3, 32'hFFFF_FFF0);   // bgeu, largest offset
      send_item(32'h0000_2063, 32'h0000_1000);   // branch with unused funct3
      send_item(32'hFFF0_0067, 32'h0000_0000);   // jalr, offset -1
      send_item(32'h0000_1067, 32'h0000_0000);   // jalr with funct3 not zero
      send_item(32'h8000_2003, 32'h0000_0000);   // lw, most negative offset
      send_item(32'h0000_3003, 32'h0000_0000);   // load with unused funct3
      send_item(32'hFE00_2FA3, 32'h0000_0000);   // sw, offset -1 split across fields
      send_item(32'h7FF0_0013, 32'h0000_0000);   // addi, largest immediate
      send_item(32'h01F0_1013, 32'h0000_0000);   // slli by 31
      send_item(32'h0200_1013, 32'h0000_0000);   // slli with nonzero funct7
      send_item(32'h41F0_5013, 32'h0000_0000);   // srai by 31
      send_item(32'h4200_5013, 32'h0000_0000);   // right shift with bad funct7
      send_item(32'h4000_0033, 32'h0000_0000);   // sub
      send_item(32'h4000_1033, 32'h0000_0000);   // alternate funct7 on sll slot
      send_item(32'h0200_7033, 32'h0000_0000);   // remu
      send_item(32'h0FF0_000F, 32'h0000_0000);   // fence
      send_item(32'h0000_100F, 32'h0000_0000);   // fence opcode, funct3 not zero
      send_item(32'h0010_0073, 32'h0000_0000);   // ebreak
      send_item(32'h000F_8F73, 32'h0000_0000);   // ecall with rd and rs1 set
      send_item(32'h0030_0073, 32'h0000_0000);   // system with bit 21 set
      send_item(32'h0000_1073, 32'h0000_0000);   // csr access is unknown here
   endtask

   task automatic test_each_mnemonic();
      for (int m = MN_LUI; m <= MN_EBREAK; m++) send_item(encode_mnemonic(6'(m)), random_pc());
   endtask

   // Mostly valid instructions with random fields, the rest near misses and noise.
   task automatic test_random_traffic(input int count);
      logic [31:0] w;
      int          pick;
      int          k;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            w = encode_mnemonic(6'($urandom_range(MN_EBREAK, MN_LUI)));
         end else if (pick < 88) begin
            w = $urandom();
            k = $urandom_range(10);
            w[6:0] = OPCODE_LIST[k * 7 +: 7];
         end else begin
            w = $urandom();
         end
         send_item(w, random_pc());
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      idle_pct = 13;
      error_count = 0;
      items_taken = 0;
      results_checked = 0;
      stall_cycles = 0;
      mnemonics_seen = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_each_mnemonic();
      test_random_traffic(450);
      drain_pending();

      idle_pct = 63;
      test_random_traffic(450);
      drain_pending();

      idle_pct = 0;
      test_random_traffic(450);
      drain_pending();
      repeat (4) @(posedge clock);

      $display("Decoded %0d instruction words, checked %0d results field by field.",
               items_taken, results_checked);
      $display("Distinct mnemonic codes produced, unknown included: %0d of 49.",
               $countones(mnemonics_seen));
      if (error_count == 0 && pending_decodes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
